// ===== hdl/otsu_threshold_smoothed_defines.svh =====
// Assertion macros for the Otsu threshold block.
// Needs a clock named clk and a synchronous reset named rst in the using module.
`ifndef OTSU_THRESHOLD_SMOOTHED_DEFINES_SVH
`define OTSU_THRESHOLD_SMOOTHED_DEFINES_SVH

// same-cycle implication
`define OTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("otsu check failed");

// next-cycle implication
`define OTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("otsu check failed");

`endif

// ===== hdl/otsu_pkg.sv =====
// Shared types and constants for the Otsu threshold block.
// No dependencies.
package otsu_pkg;

  localparam int BIN_DIVISOR_DEF = 2;
  localparam int NUM_BINS_DEF    = 128;

  localparam int DIV_W = 32;
  localparam int DVS_W = 16;

  localparam logic [15:0] KEEP_COEF = 16'd62259;
  localparam logic [11:0] NEW_COEF  = 12'd3277;

  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_SEARCH_MIN = 2'd1;
  localparam logic [1:0] CFG_SEARCH_MAX = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       fresh;
  } out_word_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DRAIN, ST_SUM_RD, ST_SUM_AC, ST_SETUP,
    ST_SCAN_RD, ST_SCAN_UP, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_CMP,
    ST_NEXT, ST_FINAL, ST_MEAN_DIV, ST_MIX1, ST_MIX2, ST_THR
  } state_t;

endpackage

// ===== hdl/otsu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module otsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/otsu_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on otsu_pkg.
module otsu_div import otsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic             ge;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= CW'(DIV_W);
      end else if (cnt != '0) begin
        rem  <= ge ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
        quo  <= {quo[DIV_W-2:0], ge};
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== hdl/otsu_threshold_smoothed.sv =====
// Top level of the smoothed Otsu threshold block: histogram RAM, frame-end search.
// Depends on otsu_pkg, otsu_ram, otsu_div and otsu_threshold_smoothed_defines.svh.
//
// Pixels are taken one per clock while busy is low; a read-modify-write on the
// histogram RAM with forwarding of the previous write keeps that pace. The word
// marked frame_end starts the search and busy stays high until the histogram is
// cleared again: a drain step (straight to clearing when disabled), a totals pass,
// a setup step, the search, where each bin in range with both sides populated goes
// through the 32-step serial dividers, a bin with an empty background is skipped
// and an empty foreground ends the search, then the mean and smoothing, then the
// clearing. After reset busy is high while the RAM is cleared. The result appears
// on result for one cycle with done high and must be taken then.
`include "otsu_threshold_smoothed_defines.svh"
module otsu_threshold_smoothed import otsu_pkg::*; #(
  parameter int BIN_DIVISOR = BIN_DIVISOR_DEF,
  parameter int NUM_BINS    = NUM_BINS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  item,
  output logic      busy,
  output logic      done,
  output out_word_t result,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int BW    = $clog2(NUM_BINS);
  localparam int HW    = 16 + BW;
  localparam int RECIP = (65536 + BIN_DIVISOR - 1) / BIN_DIVISOR;

  // divide by the bin width through a reciprocal, exact for 8-bit operands
  function automatic logic [7:0] div_bd(input logic [7:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'(RECIP);
    return p[23:16];
  endfunction

  state_t state, state_next;

  logic       enable;
  logic [7:0] search_min, search_max;

  logic [BW-1:0] idx;
  logic          s1_valid, fw_valid;
  logic [BW-1:0] s1_bin, fw_bin;
  logic [15:0]   fw_val;

  logic          ram_we;
  logic [BW-1:0] ram_waddr, ram_raddr, bin_in;
  logic [15:0]   ram_wdata, rdata, cnt_cur, cnt_inc;
  logic [7:0]    pq;

  logic [7:0] lo, hi, hi_raw;
  logic [15:0] bn, fn, tn, bn_new, fn_new;
  logic [31:0] bs, fs, ts, hx, bs_new, fs_new;
  logic [31:0] p1, p2, score, best;
  logic [15:0] dreg, acc;
  logic [8:0]  nwin;
  logic [23:0] mean, smoothed;
  logic [39:0] prod_k;
  logic [35:0] prod_n;
  logic [40:0] mix;
  logic [31:0] sbd;
  logic [7:0]  thr, held;
  logic        seeded;
  logic        accept;
  logic [15:0] qa, qb;

  div_req_t req_a, req_b;
  div_rsp_t rsp_a, rsp_b;

  assign accept = start && !busy;
  assign pq     = div_bd(item.pixel);
  assign bin_in = (32'(pq) >= NUM_BINS) ? BW'(NUM_BINS - 1) : pq[BW-1:0];

  assign lo     = div_bd(search_min);
  assign hi_raw = div_bd(search_max);
  assign hi     = (32'(hi_raw) > NUM_BINS - 1) ? 8'(NUM_BINS - 1) : hi_raw;

  assign cnt_cur = (fw_valid && fw_bin == s1_bin) ? fw_val : rdata;
  assign cnt_inc = cnt_cur + 16'd1;

  assign hx     = 32'(HW'(rdata) * HW'(idx));
  assign bn_new = bn + rdata;
  assign fn_new = fn - rdata;
  assign bs_new = bs + hx;
  assign fs_new = fs - hx;
  assign qa     = rsp_a.quotient[15:0];
  assign qb     = rsp_b.quotient[15:0];
  assign mix    = 41'(prod_k) + 41'(prod_n);
  assign sbd    = 32'(smoothed) * 32'(BIN_DIVISOR);
  assign thr    = (sbd[31:16] > 16'd255) ? 8'd255 : sbd[23:16];

  otsu_ram #(.WIDTH(16), .DEPTH(NUM_BINS)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  otsu_div u_div_a (.clk(clk), .rst(rst), .req(req_a), .rsp(rsp_a));
  otsu_div u_div_b (.clk(clk), .rst(rst), .req(req_b), .rsp(rsp_b));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (idx == BW'(NUM_BINS - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (accept && item.frame_end) state_next = ST_DRAIN;
      ST_DRAIN:    state_next = enable ? ST_SUM_RD : ST_CLEAR;
      ST_SUM_RD:   state_next = ST_SUM_AC;
      ST_SUM_AC:   state_next = (idx == BW'(NUM_BINS - 1)) ? ST_SETUP : ST_SUM_RD;
      ST_SETUP:    state_next = (lo > hi) ? ST_FINAL : ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_UP;
      ST_SCAN_UP: begin
        priority if (bn_new == 16'd0) state_next = ST_NEXT;
        else if (fn_new == 16'd0)     state_next = ST_FINAL;
        else                          state_next = ST_DIV;
      end
      ST_DIV:      if (rsp_a.done) state_next = ST_MUL1;
      ST_MUL1:     state_next = ST_MUL2;
      ST_MUL2:     state_next = ST_MUL3;
      ST_MUL3:     state_next = ST_CMP;
      ST_CMP:      state_next = ST_NEXT;
      ST_NEXT:     state_next = (9'(idx) == 9'(hi)) ? ST_FINAL : ST_SCAN_RD;
      ST_FINAL:    state_next = (nwin == 9'd0) ? ST_CLEAR : ST_MEAN_DIV;
      ST_MEAN_DIV: if (rsp_a.done) state_next = ST_MIX1;
      ST_MIX1:     state_next = ST_MIX2;
      ST_MIX2:     state_next = ST_THR;
      ST_THR:      state_next = ST_CLEAR;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state != ST_IDLE);
    ram_raddr = (state == ST_IDLE) ? bin_in : idx;
    ram_we    = s1_valid || (state == ST_CLEAR);
    ram_waddr = s1_valid ? s1_bin : idx;
    ram_wdata = s1_valid ? cnt_inc : 16'd0;
    req_a     = '{go: 1'b0, dividend: bs_new, divisor: bn_new};
    req_b     = '{go: 1'b0, dividend: fs_new, divisor: fn_new};
    if (state == ST_SCAN_UP && bn_new != 16'd0 && fn_new != 16'd0) begin
      req_a.go = 1'b1;
      req_b.go = 1'b1;
    end
    if (state == ST_FINAL) begin
      req_a.go       = (nwin != 9'd0);
      req_a.dividend = {acc, 16'd0};
      req_a.divisor  = 16'(nwin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      s1_valid   <= 1'b0;
      fw_valid   <= 1'b0;
      done       <= 1'b0;
      seeded     <= 1'b0;
      smoothed   <= '0;
      held       <= '0;
      enable     <= 1'b1;
      search_min <= 8'd0;
      search_max <= 8'd255;
    end else begin
      state    <= state_next;
      s1_valid <= accept;
      fw_valid <= s1_valid;
      done     <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     enable     <= cfg_data[0];
          CFG_SEARCH_MIN: search_min <= cfg_data;
          CFG_SEARCH_MAX: search_max <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: idx <= idx + BW'(1);
        ST_IDLE:  idx <= '0;
        ST_DRAIN: begin
          idx <= '0;
          bn <= '0; bs <= '0; tn <= '0; ts <= '0;
          best <= '0; acc <= '0; nwin <= '0;
          if (!enable) begin
            done   <= 1'b1;
            result <= '{threshold: 8'd0, fresh: 1'b0};
          end
        end
        ST_SUM_AC: begin
          tn <= tn + rdata;
          ts <= ts + hx;
          if (9'(idx) < 9'(lo)) begin
            bn <= bn_new;
            bs <= bs_new;
          end
          idx <= idx + BW'(1);
        end
        ST_SETUP: begin
          fn  <= tn - bn;
          fs  <= ts - bs;
          idx <= lo[BW-1:0];
        end
        ST_SCAN_UP: begin
          bn <= bn_new;
          fn <= fn_new;
          if (bn_new != 16'd0 && fn_new != 16'd0) begin
            bs <= bs_new;
            fs <= fs_new;
          end
        end
        ST_MUL1: begin
          p1   <= 32'(bn) * 32'(fn);
          dreg <= (qa > qb) ? qa - qb : qb - qa;
        end
        ST_MUL2: p2    <= 32'(p1 * 32'(dreg));
        ST_MUL3: score <= 32'(p2 * 32'(dreg));
        ST_CMP: begin
          if (score != 32'd0) begin
            priority if (score > best) begin
              best <= score;
              acc  <= 16'(idx);
              nwin <= 9'd1;
            end else if (score == best) begin
              acc  <= acc + 16'(idx);
              nwin <= nwin + 9'd1;
            end
          end
        end
        ST_NEXT: idx <= idx + BW'(1);
        ST_FINAL: begin
          idx <= '0;
          if (nwin == 9'd0) begin
            done   <= 1'b1;
            result <= '{threshold: held, fresh: 1'b0};
          end
        end
        ST_MEAN_DIV: begin
          if (rsp_a.done) begin
            mean <= rsp_a.quotient[23:0];
            if (!seeded) begin
              smoothed <= rsp_a.quotient[23:0];
              seeded   <= 1'b1;
            end
          end
        end
        ST_MIX1: begin
          prod_k <= 40'(smoothed) * 40'(KEEP_COEF);
          prod_n <= 36'(mean) * 36'(NEW_COEF);
        end
        ST_MIX2: smoothed <= mix[39:16];
        ST_THR: begin
          idx    <= '0;
          held   <= thr;
          done   <= 1'b1;
          result <= '{threshold: thr, fresh: 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_bin <= bin_in;
    fw_bin <= s1_bin;
    fw_val <= cnt_inc;
  end

  `OTS_ASSERT_IMP(a_done_to_clear, done, state == ST_CLEAR)
  `OTS_ASSERT_NXT(a_done_single, done, !done)
  `OTS_ASSERT_IMP(a_s1_no_scan, s1_valid, state == ST_IDLE || state == ST_DRAIN)
  `OTS_ASSERT_IMP(a_div_in_wait, rsp_a.done, state == ST_DIV || state == ST_MEAN_DIV)

endmodule

// ===== test/otsu_threshold_smoothed_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for otsu_threshold_smoothed: a directed table, then random frames.
// Depends on otsu_pkg and the block; a local predictor computes each frame's threshold.
module otsu_threshold_smoothed_tb;
  import otsu_pkg::*;

  localparam int BIN_DIV = BIN_DIVISOR_DEF;
  localparam int NB = NUM_BINS_DEF;
  localparam int LIMIT = 3000000;

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [7:0] val;
    in_word_t   w;
    bit         typed;
    out_word_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_word_t item = '0;
  logic busy, done;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_ENABLE;
  logic [7:0] cfg_data = '0;

  logic [15:0] hist [NB];
  logic [23:0] smooth_lvl;
  logic seeded, en;
  logic [7:0] held_thr, smin, smax;

  out_word_t thr_q [$];
  int unsigned cycles = 0, errors = 0, words_sent = 0, frames_done = 0, fresh_seen = 0;
  bit quiet = 1'b0;
  row_t dir_rows [$];

  otsu_threshold_smoothed dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("otsu_threshold_smoothed_tb: FAIL");
      $finish;
    end
  end

  // compare each threshold word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      frames_done++;
      if (result.fresh) fresh_seen++;
      if (thr_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", result);
      end else begin
        out_word_t e;
        e = thr_q.pop_front();
        if (e.threshold !== result.threshold || e.fresh !== result.fresh) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want thr %0d fresh %0d, got thr %0d fresh %0d",
                     e.threshold, e.fresh, result.threshold, result.fresh);
        end
      end
    end
  end

  task automatic predict_thr(input in_word_t w, output bit has, output out_word_t r);
    int unsigned b, lo, hi, best, acc, n, h, bm, fm, d, mean, t;
    logic [15:0] bn, fn;
    logic [31:0] bs, fs;
    logic [31:0] score [NB];
    logic [63:0] mix;
    has = 1'b0;
    r = '0;
    b = w.pixel / BIN_DIV;
    if (b >= NB) b = NB - 1;
    hist[b] = hist[b] + 16'd1;
    if (!w.frame_end) return;
    has = 1'b1;
    if (!en) begin
      foreach (hist[i]) hist[i] = '0;
      return;
    end
    lo = smin / BIN_DIV;
    hi = smax / BIN_DIV;
    if (hi > NB - 1) hi = NB - 1;
    bn = '0; fn = '0; bs = '0; fs = '0;
    best = 0; acc = 0; n = 0;
    foreach (score[i]) score[i] = '0;
    for (int i = 0; i < NB; i++) begin
      h = hist[i];
      if (i < lo) begin
        bn = bn + h; bs = bs + h * i;
      end else begin
        fn = fn + h; fs = fs + h * i;
      end
    end
    for (int i = lo; i <= hi; i++) begin
      h = hist[i];
      bn = bn + h;
      fn = fn - h;
      if (bn == 0) continue;
      if (fn == 0) break;
      bs = bs + h * i;
      fs = fs - h * i;
      bm = (bs / bn) & 32'hFFFF;
      fm = (fs / fn) & 32'hFFFF;
      d = bm > fm ? bm - fm : fm - bm;
      score[i] = 32'(bn) * 32'(fn) * d * d;
    end
    for (int i = lo; i <= hi; i++) begin
      if (score[i] != 0) begin
        if (score[i] > best) begin
          best = score[i]; acc = i; n = 1;
        end else if (score[i] == best) begin
          acc += i; n++;
        end
      end
    end
    if (n != 0) begin
      mean = (acc << 16) / n;
      if (!seeded) begin
        smooth_lvl = mean[23:0]; seeded = 1'b1;
      end
      mix = 64'(KEEP_COEF) * smooth_lvl + 64'(NEW_COEF) * mean;
      smooth_lvl = mix[39:16];
      t = (64'(smooth_lvl) * BIN_DIV) >> 16;
      if (t > 255) t = 255;
      held_thr = t[7:0];
      r.fresh = 1'b1;
    end
    r.threshold = held_thr;
    foreach (hist[i]) hist[i] = '0;
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit has;
    out_word_t r;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    predict_thr(w, has, r);
    if (has) thr_q.push_back(typed ? want : r);
  endtask

  // hold until every threshold has arrived and the block is back to idle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (busy || thr_q.size() != 0);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:     en = v[0];
      CFG_SEARCH_MIN: smin = v;
      CFG_SEARCH_MAX: smax = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic row_t px(input logic [7:0] p, input bit fe);
    row_t r;
    r = '{default: '0};
    r.w.pixel = p;
    r.w.frame_end = fe;
    return r;
  endfunction

  function automatic row_t px_want(input logic [7:0] p, input logic [7:0] thr);
    row_t r;
    r = px(p, 1'b1);
    r.typed = 1'b1;
    r.want.threshold = thr;
    r.want.fresh = 1'b0;
    return r;
  endfunction

  function automatic row_t cfg(input logic [1:0] idx, input logic [7:0] v);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len);
    in_word_t w;
    int a, c, spread, mode;
    out_word_t none;
    none = '0;
    mode = $urandom_range(0, 9);
    a = $urandom_range(0, 255);
    c = $urandom_range(0, 255);
    spread = $urandom_range(0, 20);
    for (int k = 0; k < len; k++) begin
      if (mode < 7)
        w.pixel = 8'(($urandom_range(0, 1) ? a : c) + $urandom_range(0, spread));
      else
        w.pixel = 8'($urandom_range(0, 255));
      w.frame_end = (k == len - 1);
      send_word(w, 1'b0, none);
    end
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    smooth_lvl = '0; seeded = 1'b0; held_thr = '0;
    en = 1'b1; smin = 8'd0; smax = 8'd255;

    dir_rows = '{
      px_want(8'd0, 8'd0),
      px(8'd255, 1'b0), px(8'd0, 1'b1),
      px(8'd128, 1'b0), px(8'd127, 1'b0), px(8'd3, 1'b0), px(8'd250, 1'b1),
      cfg(CFG_ENABLE, 8'd0), px(8'd10, 1'b0), px_want(8'd200, 8'd0),
      cfg(CFG_ENABLE, 8'd1), cfg(CFG_SEARCH_MIN, 8'd255), cfg(CFG_SEARCH_MAX, 8'd0),
      px(8'd10, 1'b0), px(8'd200, 1'b1),
      cfg(CFG_SEARCH_MIN, 8'd100), cfg(CFG_SEARCH_MAX, 8'd100),
      px(8'd0, 1'b0), px(8'd101, 1'b0), px(8'd255, 1'b1),
      cfg(CFG_SEARCH_MIN, 8'd0), cfg(CFG_SEARCH_MAX, 8'd255),
      px(8'd0, 1'b0), px(8'd0, 1'b0), px(8'd2, 1'b0), px(8'd0, 1'b1),
      px(8'd60, 1'b0), px(8'd61, 1'b0), px(8'd190, 1'b0), px(8'd191, 1'b1)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_cfg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int f = 0; f < 70; f++) begin
      quiet = (f >= 20 && f < 32);
      if (f % 6 == 5) begin
        wait_idle();
        write_cfg(CFG_ENABLE, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'd1);
        write_cfg(CFG_SEARCH_MIN, ($urandom_range(0, 1)) ? 8'd0 : pick_level());
        write_cfg(CFG_SEARCH_MAX, ($urandom_range(0, 1)) ? 8'd255 : pick_level());
      end
      send_frame($urandom_range(1, 22));
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d pixel words over %0d frames, %0d with a fresh threshold",
             words_sent, frames_done, fresh_seen);
    $display("errors %0d, thresholds still awaited %0d", errors, thr_q.size());
    if (errors == 0 && thr_q.size() == 0) begin
      $display("otsu_threshold_smoothed_tb: PASS");
    end else begin
      $display("otsu_threshold_smoothed_tb: FAIL");
    end
    $finish;
  end

endmodule
